>>> design/dqs_pkg.sv
// Shared types and codes for the bounded deque with search.
package dqs_pkg;

  localparam int DEPTH_DEF = 16;
  localparam int DATA_W    = 32;
  localparam int CMD_W     = 3;
  localparam int ST_W      = 2;
  localparam int OCC_W     = 5;

  localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd0;
  localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_POP_BACK   = 3'd3;
  localparam logic [CMD_W-1:0] CMD_SEARCH     = 3'd4;

  localparam logic [ST_W-1:0] ST_OK    = 2'd0;
  localparam logic [ST_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL  = 2'd2;

  typedef enum logic [1:0] {
    CELL_HOLD = 2'd0,
    CELL_SHR  = 2'd1,
    CELL_SHL  = 2'd2,
    CELL_LOAD = 2'd3
  } cell_op_t;

  typedef struct packed {
    cell_op_t            op;
    logic [DATA_W-1:0]   key;
  } cell_ctl_t;

endpackage

>>> design/dqs_cell.sv
// One storage cell of the deque chain: holds one word and its valid bit.
module dqs_cell
  import dqs_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  cell_ctl_t         ctl,
  input  logic [DATA_W-1:0] prev_d,
  input  logic              prev_v,
  input  logic [DATA_W-1:0] next_d,
  input  logic              next_v,
  output logic [DATA_W-1:0] cell_d,
  output logic              cell_v
);

  logic [DATA_W-1:0] d_r, d_nxt;
  logic              v_r, v_nxt;

  always_comb begin
    d_nxt = d_r;
    v_nxt = v_r;
    case (ctl.op)
      CELL_SHR: begin
        d_nxt = prev_d;
        v_nxt = prev_v;
      end
      CELL_SHL: begin
        d_nxt = next_d;
        v_nxt = next_v;
      end
      CELL_LOAD: begin
        // first empty cell behind the last valid one takes the word
        if (prev_v && !v_r) begin
          d_nxt = ctl.key;
          v_nxt = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else begin
      v_r <= v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    d_r <= d_nxt;
  end

  assign cell_d = d_r;
  assign cell_v = v_r;

endmodule

>>> design/bounded_deque_with_search.sv
// Bounded deque with search: top level, a chain of cells with front at cell 0.
// Push front, push back, pop front, no-op codes, pushes on a full store and any
// command on an empty store: the result word is valid the cycle after acceptance,
// one per cycle while out_ready holds. Pop back and search rotate the whole ring
// through cell 0, one cell per cycle, taking no command; the last step waits for a free output.
// Synchronous active-low reset empties the store (valid bits and count).
module bounded_deque_with_search
  import dqs_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [CMD_W-1:0]         in_command,
  input  logic signed [DATA_W-1:0] in_value,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [ST_W-1:0]          out_status,
  output logic signed [DATA_W-1:0] out_popped_value,
  output logic                     out_found,
  output logic [OCC_W-1:0]         out_occupancy
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int TW = $clog2(DEPTH);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_ROT  = 2'b10
  } state_t;

  state_t            state_r, state_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic [TW-1:0]     step_r, step_nxt;
  logic              is_pop_r, is_pop_nxt;
  logic [DATA_W-1:0] key_r, key_nxt;
  logic              found_r, found_nxt;
  logic [DATA_W-1:0] popped_r, popped_nxt;

  logic              out_valid_r;
  logic [ST_W-1:0]   out_status_r;
  logic [DATA_W-1:0] out_popped_r;
  logic              out_found_r;
  logic [OCC_W-1:0]  out_occ_r;

  logic              out_load;
  logic [ST_W-1:0]   res_status;
  logic [DATA_W-1:0] res_popped;
  logic              res_found;

  cell_ctl_t         ctl;
  logic              kill;
  logic [DATA_W-1:0] key_in;
  logic [DATA_W-1:0] cd [DEPTH];
  logic [DEPTH-1:0]  cv;

  logic in_fire, out_free, full, empty, last_step, hit;

  assign key_in   = in_value;
  assign out_free = !out_valid_r || out_ready;
  assign in_ready = (state_r == S_IDLE) && out_free;
  assign in_fire  = in_valid && in_ready;
  assign full     = (cnt_r == CW'(DEPTH));
  assign empty    = (cnt_r == '0);
  assign last_step = (step_r == TW'(DEPTH - 1));
  assign hit      = cv[0] && (cd[0] == key_r);

  // cell chain
  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    logic [DATA_W-1:0] pd, nd;
    logic              pv, nv;
    if (k == 0) begin : g_first
      assign pd = key_in;
      assign pv = 1'b1;
    end else begin : g_mid_p
      assign pd = cd[k-1];
      assign pv = cv[k-1];
    end
    if (k == DEPTH - 1) begin : g_last
      // ring wrap; kill drops the word leaving cell 0
      assign nd = cd[0];
      assign nv = cv[0] && !kill;
    end else begin : g_mid_n
      assign nd = cd[k+1];
      assign nv = cv[k+1];
    end
    dqs_cell u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .ctl    (ctl),
      .prev_d (pd),
      .prev_v (pv),
      .next_d (nd),
      .next_v (nv),
      .cell_d (cd[k]),
      .cell_v (cv[k])
    );
  end

  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    step_nxt   = step_r;
    is_pop_nxt = is_pop_r;
    key_nxt    = key_r;
    found_nxt  = found_r;
    popped_nxt = popped_r;
    ctl.op     = CELL_HOLD;
    ctl.key    = key_in;
    kill       = 1'b0;
    out_load   = 1'b0;
    res_status = ST_OK;
    res_popped = '0;
    res_found  = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          out_load = 1'b1;
          case (in_command)
            CMD_PUSH_FRONT: begin
              if (full) begin
                res_status = ST_FULL;
              end else begin
                ctl.op  = CELL_SHR;
                cnt_nxt = cnt_r + CW'(1);
              end
            end
            CMD_PUSH_BACK: begin
              if (full) begin
                res_status = ST_FULL;
              end else begin
                ctl.op  = CELL_LOAD;
                cnt_nxt = cnt_r + CW'(1);
              end
            end
            CMD_POP_FRONT: begin
              if (empty) begin
                res_status = ST_EMPTY;
              end else begin
                ctl.op     = CELL_SHL;
                kill       = 1'b1;
                res_popped = cd[0];
                cnt_nxt    = cnt_r - CW'(1);
              end
            end
            CMD_POP_BACK, CMD_SEARCH: begin
              if (empty) begin
                res_status = ST_EMPTY;
              end else begin
                out_load   = 1'b0;
                state_nxt  = S_ROT;
                step_nxt   = '0;
                is_pop_nxt = (in_command == CMD_POP_BACK);
                key_nxt    = key_in;
                found_nxt  = 1'b0;
                popped_nxt = '0;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_ROT: begin
        if (!last_step || out_free) begin
          ctl.op   = CELL_SHL;
          kill     = is_pop_r && (CW'(step_r) == cnt_r - CW'(1));
          step_nxt = step_r + TW'(1);
          if (kill) begin
            popped_nxt = cd[0];
          end
          if (!is_pop_r && hit) begin
            found_nxt = 1'b1;
          end
          if (last_step) begin
            state_nxt  = S_IDLE;
            out_load   = 1'b1;
            res_popped = popped_nxt;
            res_found  = found_nxt;
            if (is_pop_r) begin
              cnt_nxt = cnt_r - CW'(1);
            end
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    step_r   <= step_nxt;
    is_pop_r <= is_pop_nxt;
    key_r    <= key_nxt;
    found_r  <= found_nxt;
    popped_r <= popped_nxt;
    if (out_load) begin
      out_status_r <= res_status;
      out_popped_r <= res_popped;
      out_found_r  <= res_found;
      out_occ_r    <= OCC_W'(cnt_nxt);
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_popped_value = $signed(out_popped_r);
  assign out_found        = out_found_r;
  assign out_occupancy    = out_occ_r;

`ifndef ASSERT_OFF
  // at rest the valid bits match the count exactly
  a_count_matches: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> ($countones(cv) == cnt_r))
    else $error("occupancy count disagrees with cell valid bits");

  // at rest the stored words sit packed from cell 0
  a_packed: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> ((cv & (cv + DEPTH'(1))) == '0))
    else $error("cell chain is not packed from the front");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(DEPTH))
    else $error("occupancy beyond depth");
`endif

endmodule
